// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the shortest-path block. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check on every clock edge outside reset
`define SPDG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every clock edge, reset included
`define SPDG_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SPDG_ASSERT(lbl, prop, msg)
`define SPDG_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: hdl/spdg_pkg.sv
// ----------------------------------------------------------------------------
// spdg_pkg
// Shared types and constants of the dense-graph shortest-path block: transfer
// payloads, register indexes, result kinds and controller/datapath signals.
// ----------------------------------------------------------------------------
package spdg_pkg;

	// Fixed field widths
	localparam int NODE_W       = 3;
	localparam int DIST_W       = 12;
	localparam int KIND_W       = 2;
	localparam int EDGE_W       = 8;
	localparam int WEIGHT_MAX_W = 16;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 3;

	// Distance that marks an unreachable node
	localparam logic [DIST_W-1:0] DIST_INF = '1;

	// Input opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RUN  = 1'b1;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_DIST    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PATH    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_UNREACH = 2'd2;

	// Register indexes and reset values
	localparam logic [CFG_IDX_W-1:0]  REG_SOURCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0]  REG_TARGET = 1'b1;
	localparam logic [CFG_DATA_W-1:0] SRC_RESET  = 3'd0;
	localparam logic [CFG_DATA_W-1:0] TGT_RESET  = 3'd4;

	typedef struct packed {
		logic              opcode;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
		logic [EDGE_W-1:0] edge_weight;
	} in_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [NODE_W-1:0] node_id;
		logic [DIST_W-1:0] distance;
		logic              last;
	} out_t;

	// Datapath operation for the current cycle
	typedef enum logic [3:0] {
		M_NONE,
		M_CLEAR,
		M_LOAD,
		M_INIT,
		M_SEL,
		M_RELAX,
		M_EMIT,
		M_TGT,
		M_BT,
		M_PATH
	} mode_t;

	// Controller to datapath
	typedef struct packed {
		mode_t mode;
		logic  rd;     // issue a memory read
		logic  fire;   // act on the data read before
		logic  first;  // first step of a pass
		logic  last;   // final path result
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic slot_free;
		logic found;
		logic hit;
		logic tgt_reach;
		logic cur_is_src;
	} sts_t;

endpackage

// File: hdl/spdg_ram.sv
// ----------------------------------------------------------------------------
// spdg_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module spdg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/spdg_ctrl.sv
// ----------------------------------------------------------------------------
// spdg_ctrl
// Sequencer of the shortest-path block: memory clear after reset, edge loads,
// search rounds, distance emission, backtracking and path emission.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spdg_ctrl import spdg_pkg::*; #(
	parameter int NODES = 8,
	localparam int NW = $clog2(NODES),
	localparam int CW = 2 * NW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          opcode,
	output logic          in_stall,
	input  sts_t          sts,
	output cmd_t          cmd,
	output logic [NW-1:0] idx,
	output logic [NW-1:0] pidx,
	output logic [CW-1:0] caddr
);

	localparam logic [NW:0] IDX_END  = (NW + 1)'(NODES);
	localparam logic [NW:0] IDX_LAST = (NW + 1)'(NODES - 1);
	localparam logic [NW:0] LEN_ONE  = (NW + 1)'(1);

	typedef enum logic [10:0] {
		ST_CLEAR  = 11'b00000000001,
		ST_IDLE   = 11'b00000000010,
		ST_INIT   = 11'b00000000100,
		ST_SEL    = 11'b00000001000,
		ST_DEC    = 11'b00000010000,
		ST_RELAX  = 11'b00000100000,
		ST_EMIT   = 11'b00001000000,
		ST_TGT    = 11'b00010000000,
		ST_BT_CHK = 11'b00100000000,
		ST_BT     = 11'b01000000000,
		ST_PATH   = 11'b10000000000
	} state_t;

	state_t        state_q, state_d;
	logic [NW:0]   idx_q, idx_d;
	logic [NW:0]   len_q, len_d;
	logic [NW:0]   len_m1;
	logic [CW-1:0] clr_q, clr_d;
	logic          ph_q, ph_d;

	assign len_m1 = len_q - LEN_ONE;
	assign idx    = idx_q[NW-1:0];
	assign pidx   = (state_q == ST_PATH) ? len_m1[NW-1:0] : len_q[NW-1:0];
	assign caddr  = clr_q;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		len_d    = len_q;
		clr_d    = clr_q;
		ph_d     = ph_q;
		in_stall = 1'b1;
		cmd      = '{mode: M_NONE, rd: 1'b0, fire: 1'b0, first: 1'b0, last: 1'b0};
		case (state_q)
			// Sweep the weight memory to zero
			ST_CLEAR: begin
				cmd.mode = M_CLEAR;
				clr_d    = clr_q + 1'b1;
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			// Take loads in place, start a run on a run item
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (opcode == OP_LOAD) begin
						cmd.mode = M_LOAD;
					end else begin
						idx_d   = '0;
						state_d = ST_INIT;
					end
				end
			end
			// Preset every distance
			ST_INIT: begin
				cmd.mode  = M_INIT;
				cmd.first = (idx_q == '0);
				idx_d     = idx_q + 1'b1;
				if (idx_q == IDX_LAST) begin
					idx_d   = '0;
					state_d = ST_SEL;
				end
			end
			// Scan for the closest unvisited node
			ST_SEL: begin
				cmd.mode  = M_SEL;
				cmd.rd    = (idx_q != IDX_END);
				cmd.first = (idx_q == '0);
				idx_d     = idx_q + 1'b1;
				if (idx_q == IDX_END) begin
					idx_d   = '0;
					state_d = ST_DEC;
				end
			end
			// Visit the pick, or finish the search
			ST_DEC: begin
				cmd.mode = M_SEL;
				if (sts.found) begin
					cmd.fire = 1'b1;
					state_d  = ST_RELAX;
				end else begin
					state_d = ST_EMIT;
				end
			end
			// Relax all neighbors of the pick
			ST_RELAX: begin
				cmd.mode = M_RELAX;
				cmd.rd   = (idx_q != IDX_END);
				idx_d    = idx_q + 1'b1;
				if (idx_q == IDX_END) begin
					idx_d   = '0;
					state_d = ST_SEL;
				end
			end
			// Emit distances in node order, one read then one transfer
			ST_EMIT: begin
				cmd.mode = M_EMIT;
				if (!ph_q) begin
					cmd.rd = 1'b1;
					ph_d   = 1'b1;
				end else if (sts.slot_free) begin
					cmd.fire = 1'b1;
					ph_d     = 1'b0;
					idx_d    = idx_q + 1'b1;
					if (idx_q == IDX_LAST) begin
						idx_d   = '0;
						state_d = ST_TGT;
					end
				end
			end
			// Check the target, seed the backtrack or flag it unreachable
			ST_TGT: begin
				cmd.mode = M_TGT;
				if (!ph_q) begin
					cmd.rd = 1'b1;
					ph_d   = 1'b1;
				end else if (sts.tgt_reach) begin
					cmd.fire = 1'b1;
					ph_d     = 1'b0;
					len_d    = LEN_ONE;
					state_d  = ST_BT_CHK;
				end else if (sts.slot_free) begin
					cmd.fire = 1'b1;
					ph_d     = 1'b0;
					state_d  = ST_IDLE;
				end
			end
			// Stop at the source or at a full path
			ST_BT_CHK: begin
				cmd.mode = M_BT;
				idx_d    = '0;
				if (sts.cur_is_src || len_q == IDX_END) begin
					state_d = ST_PATH;
				end else begin
					state_d = ST_BT;
				end
			end
			// Find the lowest-index predecessor of the current node
			ST_BT: begin
				cmd.mode = M_BT;
				cmd.rd   = (idx_q != IDX_END);
				idx_d    = idx_q + 1'b1;
				if (sts.hit) begin
					idx_d   = '0;
					len_d   = len_q + 1'b1;
					state_d = ST_BT_CHK;
				end else if (idx_q == IDX_END) begin
					state_d = ST_PATH;
				end
			end
			// Emit the path source first
			ST_PATH: begin
				cmd.mode = M_PATH;
				if (!ph_q) begin
					cmd.rd = 1'b1;
					ph_d   = 1'b1;
				end else if (sts.slot_free) begin
					cmd.fire = 1'b1;
					cmd.last = (len_q == LEN_ONE);
					ph_d     = 1'b0;
					len_d    = len_m1;
					if (len_q == LEN_ONE) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q   <= '0;
			len_q   <= '0;
			clr_q   <= '0;
			ph_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			len_q   <= len_d;
			clr_q   <= clr_d;
			ph_q    <= ph_d;
		end
	end

	`SPDG_ASSERT_ALWAYS(a_len_range, (len_q <= IDX_END), "path length beyond node count")
	`SPDG_ASSERT(a_hit_step, (state_q == ST_BT && sts.hit) |=> (state_q == ST_BT_CHK),
		"backtrack hit did not advance")

endmodule

// File: hdl/spdg_dp.sv
// ----------------------------------------------------------------------------
// spdg_dp
// Datapath of the shortest-path block: weight, distance and path memories,
// search registers, configuration registers and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spdg_dp import spdg_pkg::*; #(
	parameter int NODES = 8,
	parameter int WEIGHT_BITS = 8,
	localparam int NW = $clog2(NODES),
	localparam int CW = 2 * NW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_t                   in_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  cmd_t                  cmd,
	input  logic [NW-1:0]         idx,
	input  logic [NW-1:0]         pidx,
	input  logic [CW-1:0]         caddr,
	output sts_t                  sts,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data
);

	localparam int EW    = NW + NODE_W;
	localparam int SUM_W = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;
	localparam int PW    = NW + DIST_W;

	// Configuration
	logic [NODE_W-1:0] src_q, tgt_q;

	// Node field conversions
	logic [EW-1:0]     a_ext, b_ext, src_ext, tgt_ext, idx_ext, pn_ext;
	logic [NW-1:0]     a_idx, b_idx, src_idx, tgt_idx;
	logic              a_ok, b_ok, src_ok, tgt_ok;

	// Weight memory
	logic [NW-1:0]          px, py;
	logic [CW-1:0]          canon;
	logic [WEIGHT_MAX_W-1:0] w_ext;
	logic                   w_we, w_re;
	logic [CW-1:0]          w_waddr;
	logic [WEIGHT_BITS-1:0] w_wdata, w_rd;

	// Distance memory
	logic              d_we, d_re;
	logic [NW-1:0]     d_waddr, d_raddr;
	logic [DIST_W-1:0] d_wdata, d_rd, init_val;

	// Path memory
	logic              p_we, p_re;
	logic [NW-1:0]     p_waddr;
	logic [PW-1:0]     p_wdata, p_rd;
	logic [NW-1:0]     p_node;
	logic [DIST_W-1:0] p_dist;

	// Search state
	logic              vld_s1;
	logic [NW-1:0]     idx_s1;
	logic [NODES-1:0]  unv_q;
	logic [DIST_W-1:0] best_q, dcur_q;
	logic [NW-1:0]     pick_q, cur_q;
	logic              found_q;
	logic [SUM_W-1:0]  rel_sum, bt_sum;
	logic [DIST_W-1:0] cand;
	logic              relax_wr, hit, tgt_reach, scan_rd, seed;

	// Output register
	logic out_load, out_valid_q;
	out_t out_d, out_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= SRC_RESET;
			tgt_q <= TGT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_SOURCE) begin
				src_q <= cfg_data;
			end
			if (cfg_index == REG_TARGET) begin
				tgt_q <= cfg_data;
			end
		end
	end

	// Range checks and index forms of node fields
	assign a_ext   = EW'(in_data.node_a);
	assign b_ext   = EW'(in_data.node_b);
	assign src_ext = EW'(src_q);
	assign tgt_ext = EW'(tgt_q);
	assign a_idx   = a_ext[NW-1:0];
	assign b_idx   = b_ext[NW-1:0];
	assign src_idx = src_ext[NW-1:0];
	assign tgt_idx = tgt_ext[NW-1:0];
	assign a_ok    = (32'(in_data.node_a) < 32'(NODES));
	assign b_ok    = (32'(in_data.node_b) < 32'(NODES));
	assign src_ok  = (32'(src_q) < 32'(NODES));
	assign tgt_ok  = (32'(tgt_q) < 32'(NODES));
	assign idx_ext = EW'(idx);

	// Pick the node pair, store and read the matrix by its upper triangle
	always_comb begin
		case (cmd.mode)
			M_LOAD: begin
				px = a_idx;
				py = b_idx;
			end
			M_RELAX: begin
				px = pick_q;
				py = idx;
			end
			M_BT: begin
				px = idx;
				py = cur_q;
			end
			default: begin
				px = idx;
				py = idx;
			end
		endcase
	end
	assign canon = (px < py) ? {px, py} : {py, px};

	assign scan_rd = cmd.rd && (cmd.mode inside {M_SEL, M_RELAX, M_BT});

	assign w_ext   = WEIGHT_MAX_W'(in_data.edge_weight);
	assign w_we    = (cmd.mode == M_CLEAR) || (cmd.mode == M_LOAD && a_ok && b_ok);
	assign w_waddr = (cmd.mode == M_CLEAR) ? caddr : canon;
	assign w_wdata = (cmd.mode == M_CLEAR) ? '0 : w_ext[WEIGHT_BITS-1:0];
	assign w_re    = cmd.rd && (cmd.mode inside {M_RELAX, M_BT});

	spdg_ram #(
		.WIDTH (WEIGHT_BITS),
		.DEPTH (1 << CW)
	) u_wram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (w_wdata),
		.re    (w_re),
		.raddr (canon),
		.rdata (w_rd)
	);

	// Relaxation candidate, saturated at the unreachable mark
	assign rel_sum  = SUM_W'(best_q) + SUM_W'(w_rd);
	assign cand     = (rel_sum > SUM_W'(DIST_INF)) ? DIST_INF : rel_sum[DIST_W-1:0];
	assign relax_wr = (cmd.mode == M_RELAX) && vld_s1 && (w_rd != '0) && (cand < d_rd);

	// Predecessor test for the backtrack
	assign bt_sum = SUM_W'(d_rd) + SUM_W'(w_rd);
	assign hit    = (cmd.mode == M_BT) && vld_s1 && (w_rd != '0) && (d_rd != DIST_INF) &&
		(bt_sum == SUM_W'(dcur_q));

	assign tgt_reach = tgt_ok && (d_rd != DIST_INF);
	assign seed      = (cmd.mode == M_TGT) && cmd.fire && tgt_reach;

	// Distance memory ports
	assign init_val = (src_ok && idx == src_idx) ? '0 : DIST_INF;
	assign d_we     = (cmd.mode == M_INIT) || relax_wr;
	assign d_waddr  = relax_wr ? idx_s1 : idx;
	assign d_wdata  = relax_wr ? cand : init_val;
	assign d_re     = cmd.rd && (cmd.mode inside {M_SEL, M_RELAX, M_EMIT, M_TGT, M_BT});
	assign d_raddr  = (cmd.mode == M_TGT) ? tgt_idx : idx;

	spdg_ram #(
		.WIDTH (DIST_W),
		.DEPTH (NODES)
	) u_dram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.re    (d_re),
		.raddr (d_raddr),
		.rdata (d_rd)
	);

	// Path memory holds node and its distance, target first
	assign p_we    = hit || seed;
	assign p_waddr = hit ? pidx : '0;
	assign p_wdata = hit ? {idx_s1, d_rd} : {tgt_idx, d_rd};
	assign p_re    = cmd.rd && (cmd.mode == M_PATH);
	assign p_node  = p_rd[PW-1:DIST_W];
	assign p_dist  = p_rd[DIST_W-1:0];
	assign pn_ext  = EW'(p_node);

	spdg_ram #(
		.WIDTH (PW),
		.DEPTH (NODES)
	) u_pram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.re    (p_re),
		.raddr (pidx),
		.rdata (p_rd)
	);

	// Scan pipeline; drop the read that trails a backtrack hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= scan_rd && !hit;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx;
	end

	// Selection, visit marks and backtrack cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unv_q   <= '1;
			found_q <= 1'b0;
			best_q  <= DIST_INF;
			pick_q  <= '0;
			cur_q   <= '0;
			dcur_q  <= DIST_INF;
		end else begin
			if (cmd.mode == M_INIT && cmd.first) begin
				unv_q <= '1;
			end else if (cmd.mode == M_SEL && cmd.fire) begin
				unv_q[pick_q] <= 1'b0;
			end
			if (cmd.mode == M_SEL && cmd.first) begin
				found_q <= 1'b0;
				best_q  <= DIST_INF;
			end else if (cmd.mode == M_SEL && vld_s1 && unv_q[idx_s1] && d_rd < best_q) begin
				found_q <= 1'b1;
				best_q  <= d_rd;
				pick_q  <= idx_s1;
			end
			if (seed) begin
				cur_q  <= tgt_idx;
				dcur_q <= d_rd;
			end else if (hit) begin
				cur_q  <= idx_s1;
				dcur_q <= d_rd;
			end
		end
	end

	// Result formatting
	always_comb begin
		out_load = 1'b0;
		out_d    = '{kind: KIND_DIST, node_id: idx_ext[NODE_W-1:0], distance: d_rd, last: 1'b0};
		case (cmd.mode)
			M_EMIT: begin
				out_load = cmd.fire;
			end
			M_TGT: begin
				out_load = cmd.fire && !tgt_reach;
				out_d    = '{kind: KIND_UNREACH, node_id: tgt_q, distance: DIST_INF, last: 1'b1};
			end
			M_PATH: begin
				out_load = cmd.fire;
				out_d    = '{kind: KIND_PATH, node_id: pn_ext[NODE_W-1:0], distance: p_dist,
					last: cmd.last};
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// Output register: hold while stalled, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign sts = '{
		slot_free:  (!out_valid_q || !out_stall),
		found:      found_q,
		hit:        hit,
		tgt_reach:  tgt_reach,
		cur_is_src: (src_ok && cur_q == src_idx)
	};

	`SPDG_ASSERT(a_out_slot, out_load |-> (!out_valid_q || !out_stall),
		"result loaded over a waiting result")
	`SPDG_ASSERT(a_found_best, found_q |-> (best_q != DIST_INF),
		"selected node has no finite distance")

endmodule

// File: hdl/shortest_path_dense_graph.sv
// ----------------------------------------------------------------------------
// shortest_path_dense_graph
// Single-source shortest paths over a small dense undirected graph. A load
// item is taken in place while idle and stores its weight once in a
// triangular weight memory. After reset the weight memory is swept to zero,
// one entry a cycle, with in_stall high; configuration writes are taken
// during the sweep. A run item presets the distances, then for each visited
// node runs a selection pass and a relaxation pass, ends the search with a
// final selection pass, and then emits the distance results, checks the
// target, backtracks step by step and emits the path results, all paced by
// the single read port of the distance memory. Output stalls extend the
// emission phases.
// ----------------------------------------------------------------------------
module shortest_path_dense_graph import spdg_pkg::*; #(
	parameter int NODES = 8,
	parameter int WEIGHT_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int NW = $clog2(NODES);
	localparam int CW = 2 * NW;

	cmd_t          cmd;
	sts_t          sts;
	logic [NW-1:0] idx;
	logic [NW-1:0] pidx;
	logic [CW-1:0] caddr;

	// Sequencer
	spdg_ctrl #(
		.NODES (NODES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (in_data.opcode),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd),
		.idx      (idx),
		.pidx     (pidx),
		.caddr    (caddr)
	);

	// Memories, search registers and output register
	spdg_dp #(
		.NODES       (NODES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.idx       (idx),
		.pidx      (pidx),
		.caddr     (caddr),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
